// File: src/ppr_pkg.sv
// pending packet route table: shared types, codes and constants
// used by the interfaces, the table cell and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int MAX_RESULTS       = 16;
	localparam int CNT_W             = $clog2(MAX_RESULTS);
	localparam int MODE_W            = 2;
	localparam int KEY_W             = 32;
	localparam int ID_W              = 32;
	localparam int KIND_W            = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD     = 2'd0,
		MODE_DROP    = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED  = 3'd0,
		KIND_FULL   = 3'd1,
		KIND_DROP   = 3'd2,
		KIND_ACCEPT = 3'd3,
		KIND_NONE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD     = 2'd0,
		CELL_SHIFT_IN = 2'd1,
		CELL_REMOVE   = 2'd2
	} cell_op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] route;
		logic [ID_W-1:0]  packet;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t         op;
		logic             by_route;
		logic [KEY_W-1:0] route;
		logic [ID_W-1:0]  packet;
	} cell_ctrl_t;

	// match summary handed from cell to cell, newest side first
	typedef struct packed {
		logic            found;
		logic            more;
		logic [ID_W-1:0] id;
	} chain_t;

endpackage

`default_nettype wire

// File: src/ppr_in_if.sv
// input channel of the pending packet route table: valid/ready plus item fields
// depends on ppr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ppr_in_if import ppr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  route_key;
	logic [ID_W-1:0]   packet_id;

	modport source (output valid, output mode, output route_key, output packet_id,
		input ready);
	modport sink (input valid, input mode, input route_key, input packet_id,
		output ready);
endinterface

`default_nettype wire

// File: src/ppr_out_if.sv
// result channel of the pending packet route table: valid/ready plus result fields
// depends on ppr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ppr_out_if import ppr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [ID_W-1:0]   verdict_id;
	logic              was_held;
	logic              last_result;

	modport source (output valid, output result_kind, output verdict_id,
		output was_held, output last_result, input ready);
	modport sink (input valid, input result_kind, input verdict_id,
		input was_held, input last_result, output ready);
endinterface

`default_nettype wire

// File: src/ppr_cell.sv
// one slot of the pending packet route table, linked to its two neighbors
// depends on ppr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppr_cell import ppr_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire entry_t     prev_entry,
	input  wire entry_t     next_entry,
	input  wire chain_t     chain_in,
	output entry_t          entry,
	output chain_t          chain_out
);

	logic             valid_q;
	logic [KEY_W-1:0] route_q;
	logic [ID_W-1:0]  packet_q;
	logic             hit;
	logic             first;

	assign hit   = valid_q && (ctrl.by_route ? (route_q == ctrl.route)
		: (packet_q == ctrl.packet));
	assign first = hit && !chain_in.found;

	assign chain_out.found = chain_in.found | hit;
	assign chain_out.more  = chain_in.more | (hit & chain_in.found);
	assign chain_out.id    = chain_in.id | (first ? packet_q : '0);

	assign entry.valid  = valid_q;
	assign entry.route  = route_q;
	assign entry.packet = packet_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				CELL_SHIFT_IN: valid_q <= prev_entry.valid;
				CELL_REMOVE:   if (chain_out.found) valid_q <= next_entry.valid;
				default:       valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_SHIFT_IN: begin
				route_q  <= prev_entry.route;
				packet_q <= prev_entry.packet;
			end
			CELL_REMOVE: if (chain_out.found) begin
				// at or behind the removed slot: close the gap
				route_q  <= next_entry.route;
				packet_q <= next_entry.packet;
			end
			default: begin
				route_q  <= route_q;
				packet_q <= packet_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/pending_packet_route_table.sv
// top level of the pending packet route table: controller, result register, cell row
// depends on ppr_pkg, ppr_in_if, ppr_out_if and ppr_cell
`timescale 1ns / 1ps
`default_nettype none

// The table holds up to TABLE_ENTRIES packets waiting for a route, packed with
// the newest entry in slot 0, in a row of cells that each compare their own
// entry against a broadcast key and shift toward or away from their neighbors.
// An item is taken in the idle state and worked once the result register is
// free. Add, table-full reject and drop give one result each, an unused mode
// gives no result, and a route release gives one result per released entry (at
// most MAX_RESULTS, 16), or a single none result when nothing matches. One
// entry leaves the row per cycle while the result register is free. Results
// go out through a single result register. A new item is taken while the
// last result of the previous one still waits.
module pending_packet_route_table import ppr_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input wire        clk,
	input wire        arst_n,
	ppr_in_if.sink    item,
	ppr_out_if.source result
);

	// controller state and the captured transaction
	state_t            state_q;
	state_t            state_d;
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [ID_W-1:0]   id_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;

	// result register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_held_q;
	logic              out_last_q;

	logic              out_free;
	logic              load;
	kind_t             load_kind;
	logic [ID_W-1:0]   load_id;
	logic              load_held;
	logic              load_last;

	cell_ctrl_t        ctrl;
	entry_t            entries [TABLE_ENTRIES];
	chain_t            chain   [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] valid_vec;
	logic              full;
	logic              any_hit;
	logic              more_hit;
	logic              accept_in;

	assign accept_in = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || result.ready;

	// the row of cells: slot 0 takes the new entry, the oldest slot takes an empty one
	assign chain[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;

		if (i == 0) begin : g_head
			assign prev_e = '{valid: 1'b1, route: key_q, packet: id_q};
		end else begin : g_body
			assign prev_e = entries[i-1];
		end

		if (i == TABLE_ENTRIES - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_link
			assign next_e = entries[i+1];
		end

		ppr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.chain_in   (chain[i]),
			.entry      (entries[i]),
			.chain_out  (chain[i+1])
		);

		assign valid_vec[i] = entries[i].valid;
	end

	assign full     = valid_vec[TABLE_ENTRIES-1];
	assign any_hit  = chain[TABLE_ENTRIES].found;
	assign more_hit = chain[TABLE_ENTRIES].more;

	// next state, cell command and result to load
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		ctrl.op       = CELL_HOLD;
		ctrl.by_route = (mode_t'(mode_q) == MODE_RELEASE);
		ctrl.route    = key_q;
		ctrl.packet   = id_q;
		load          = 1'b0;
		load_kind     = KIND_ADDED;
		load_id       = id_q;
		load_held     = 1'b0;
		load_last     = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					state_d = ST_EXEC;
					count_d = '0;
				end
			end
			ST_EXEC: begin
				case (mode_t'(mode_q))
					MODE_ADD: if (out_free) begin
						load      = 1'b1;
						load_kind = full ? KIND_FULL : KIND_ADDED;
						ctrl.op   = full ? CELL_HOLD : CELL_SHIFT_IN;
						state_d   = ST_IDLE;
					end
					MODE_DROP: if (out_free) begin
						// removes the newest matching id, if any
						load      = 1'b1;
						load_kind = KIND_DROP;
						load_held = any_hit;
						ctrl.op   = CELL_REMOVE;
						state_d   = ST_IDLE;
					end
					MODE_RELEASE: if (out_free) begin
						load = 1'b1;
						if (!any_hit) begin
							// only reached on the first step: later steps stop at the last match
							load_kind = KIND_NONE;
							load_id   = '0;
							state_d   = ST_IDLE;
						end else begin
							load_kind = KIND_ACCEPT;
							load_id   = chain[TABLE_ENTRIES].id;
							load_held = 1'b1;
							load_last = !more_hit || (count_q == CNT_W'(MAX_RESULTS - 1));
							ctrl.op   = CELL_REMOVE;
							count_d   = count_q + 1'b1;
							if (load_last) state_d = ST_IDLE;
						end
					end
					default: begin
						// unused mode: no result, table untouched
						state_d = ST_IDLE;
					end
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (accept_in) begin
			mode_q <= item.mode;
			key_q  <= item.route_key;
			id_q   <= item.packet_id;
		end
	end

	// result register: valid under reset, payload plain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= load_kind;
			out_id_q   <= load_id;
			out_held_q <= load_held;
			out_last_q <= load_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.verdict_id  = out_id_q;
	assign result.was_held    = out_held_q;
	assign result.last_result = out_last_q;

	// valid slots always form a prefix of the row
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[TABLE_ENTRIES-1:1] & ~valid_vec[TABLE_ENTRIES-2:0]) == '0)
		else $error("table lost its packing");

	// a drop that hits frees exactly one slot
	a_drop_frees_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && mode_t'(mode_q) == MODE_DROP && out_free && any_hit)
		|=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
		else $error("drop did not free exactly one slot");

	// a rejected add leaves the table as it was
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && mode_t'(mode_q) == MODE_ADD && out_free && full)
		|=> $stable(valid_vec))
		else $error("rejected add changed the table");

endmodule

`default_nettype wire
